FILE: hw/rtl/slec_pkg.sv
`timescale 1ns / 1ps

package slec_pkg;

  // list storage
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // port field widths
  localparam int OP_W     = 2;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  // width for position against count compares
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_FIND   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  // element store access, one write and one read port
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // finished request, shown for one cycle
  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [DATA_W-1:0] read_value;
    logic [POS_W-1:0]  found_position;
    logic [POS_W-1:0]  entry_count;
  } result_t;

endpackage

FILE: hw/rtl/sequential_list_engine_core.sv
`timescale 1ns / 1ps

// ordered list of up to 64 signed 32-bit entries with 1-based positions.
// a request (insert, delete, read, find) is taken when start is high and busy
// is low; busy then stays high until the request is finished. the result
// appears on status, read_value, found_position and entry_count for exactly
// one cycle, marked by done, which rises in the same cycle that busy falls;
// there is no way to hold it off, so capture it on done. a new request may be
// taken during the done cycle. entry_count is the count after the request.
// timing is set by the single store port, one entry moved or compared per
// cycle. insert moves the entries from position to the end up one place and
// then writes the new entry; delete moves the entries after position down
// one place; find compares entries from position 1 until a match or the end.
// the store is not cleared at reset; only written entries are ever read.

module sequential_list_engine_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [slec_pkg::OP_W-1:0]           op,
  input  logic [slec_pkg::POS_W-1:0]          position,
  input  logic signed [slec_pkg::DATA_W-1:0]  value,
  output logic                                done,
  output logic [slec_pkg::STATUS_W-1:0]       status,
  output logic signed [slec_pkg::DATA_W-1:0]  read_value,
  output logic [slec_pkg::POS_W-1:0]          found_position,
  output logic [slec_pkg::POS_W-1:0]          entry_count
);

  slec_pkg::ram_req_t             ram_req;
  slec_pkg::result_t              result;
  logic [slec_pkg::DATA_W-1:0]    rdata;

  // element store, registered read
  slec_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  // sequencer walking the store one entry per cycle
  slec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .op       (slec_pkg::op_t'(op)),
    .position (position),
    .value    (value),
    .rdata    (rdata),
    .ram_req  (ram_req),
    .result   (result),
    .busy     (busy)
  );

  // result register: one cycle strobe, payload held between results
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      status         <= result.status;
      read_value     <= result.read_value;
      found_position <= result.found_position;
      entry_count    <= result.entry_count;
    end
  end

endmodule

FILE: hw/rtl/slec_ram.sv
`timescale 1ns / 1ps

module slec_ram (
  input  logic                               clk,
  input  slec_pkg::ram_req_t                 req,
  output logic [slec_pkg::DATA_W-1:0]        rdata
);

  logic [slec_pkg::DATA_W-1:0] mem [slec_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

FILE: hw/rtl/slec_ctrl.sv
`timescale 1ns / 1ps

module slec_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  slec_pkg::op_t                     op,
  input  logic [slec_pkg::POS_W-1:0]        position,
  input  logic [slec_pkg::DATA_W-1:0]       value,
  input  logic [slec_pkg::DATA_W-1:0]       rdata,
  output slec_pkg::ram_req_t                ram_req,
  output slec_pkg::result_t                 result,
  output logic                              busy
);

  typedef enum logic [2:0] {
    S_IDLE, S_SHIFT, S_DRAIN, S_PUT, S_RDWAIT, S_SCAN, S_FINISH
  } state_t;

  state_t                            state;
  logic [slec_pkg::CNT_W-1:0]        total;
  logic [slec_pkg::CNT_W-1:0]        ptr;
  logic [slec_pkg::CNT_W-1:0]        end_ptr;
  logic                              up;
  logic                              pend;
  logic [slec_pkg::ADDR_W-1:0]       pend_addr;
  logic [slec_pkg::ADDR_W-1:0]       slot;
  logic [slec_pkg::DATA_W-1:0]       key;
  logic                              cmp_valid;
  logic [slec_pkg::CNT_W-1:0]        cmp_idx;
  slec_pkg::status_t                 res_status;
  logic [slec_pkg::DATA_W-1:0]       res_rd;
  logic [slec_pkg::POS_W-1:0]        res_found;

  logic [slec_pkg::CMP_W-1:0]        pos_ext;
  logic [slec_pkg::CMP_W-1:0]        n_ext;
  logic [slec_pkg::CMP_W-1:0]        k_ext;
  logic                              accept;

  assign pos_ext = slec_pkg::CMP_W'(position);
  assign n_ext   = slec_pkg::CMP_W'(total);
  assign k_ext   = pos_ext - slec_pkg::CMP_W'(1);
  assign accept  = start && (state == S_IDLE);
  assign busy    = (state != S_IDLE);

  // memory port: pending shift write, or the new entry
  always_comb begin
    ram_req.we    = (pend && (state == S_SHIFT || state == S_DRAIN)) || (state == S_PUT);
    ram_req.waddr = (state == S_PUT) ? slot : pend_addr;
    ram_req.wdata = (state == S_PUT) ? key : rdata;
    ram_req.raddr = (state == S_IDLE) ? k_ext[slec_pkg::ADDR_W-1:0]
                                      : ptr[slec_pkg::ADDR_W-1:0];
  end

  always_comb begin
    result.valid          = (state == S_FINISH);
    result.status         = res_status;
    result.read_value     = res_rd;
    result.found_position = res_found;
    result.entry_count    = slec_pkg::POS_W'(total);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      pend      <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            key        <= value;
            slot       <= k_ext[slec_pkg::ADDR_W-1:0];
            pend       <= 1'b0;
            cmp_valid  <= 1'b0;
            res_status <= slec_pkg::ST_OK;
            res_rd     <= '0;
            res_found  <= '0;
            unique case (op)
              slec_pkg::OP_INSERT: begin
                if (position == '0 || pos_ext > n_ext + slec_pkg::CMP_W'(1)) begin
                  res_status <= slec_pkg::ST_RANGE;
                  state      <= S_FINISH;
                end else if (n_ext == slec_pkg::CMP_W'(slec_pkg::CAPACITY)) begin
                  res_status <= slec_pkg::ST_FULL;
                  state      <= S_FINISH;
                end else if (pos_ext == n_ext + slec_pkg::CMP_W'(1)) begin
                  state <= S_PUT;
                end else begin
                  ptr     <= total - slec_pkg::CNT_W'(1);
                  end_ptr <= slec_pkg::CNT_W'(k_ext);
                  up      <= 1'b1;
                  state   <= S_SHIFT;
                end
              end
              slec_pkg::OP_DELETE: begin
                if (position == '0 || pos_ext > n_ext) begin
                  res_status <= slec_pkg::ST_RANGE;
                  state      <= S_FINISH;
                end else if (pos_ext == n_ext) begin
                  total <= total - slec_pkg::CNT_W'(1);
                  state <= S_FINISH;
                end else begin
                  ptr     <= slec_pkg::CNT_W'(pos_ext);
                  end_ptr <= total - slec_pkg::CNT_W'(1);
                  up      <= 1'b0;
                  state   <= S_SHIFT;
                end
              end
              slec_pkg::OP_READ: begin
                if (position == '0 || pos_ext > n_ext) begin
                  res_status <= slec_pkg::ST_RANGE;
                  state      <= S_FINISH;
                end else begin
                  state <= S_RDWAIT;
                end
              end
              slec_pkg::OP_FIND: begin
                if (total == '0) begin
                  res_status <= slec_pkg::ST_MISS;
                  state      <= S_FINISH;
                end else begin
                  ptr   <= '0;
                  state <= S_SCAN;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SHIFT: begin
          pend      <= 1'b1;
          pend_addr <= up ? slec_pkg::ADDR_W'(ptr + slec_pkg::CNT_W'(1))
                          : slec_pkg::ADDR_W'(ptr - slec_pkg::CNT_W'(1));
          if (ptr == end_ptr) begin
            state <= S_DRAIN;
          end else begin
            ptr <= up ? ptr - slec_pkg::CNT_W'(1) : ptr + slec_pkg::CNT_W'(1);
          end
        end
        S_DRAIN: begin
          pend <= 1'b0;
          if (up) begin
            state <= S_PUT;
          end else begin
            total <= total - slec_pkg::CNT_W'(1);
            state <= S_FINISH;
          end
        end
        S_PUT: begin
          total <= total + slec_pkg::CNT_W'(1);
          state <= S_FINISH;
        end
        S_RDWAIT: begin
          res_rd <= rdata;
          state  <= S_FINISH;
        end
        S_SCAN: begin
          if (cmp_valid && rdata == key) begin
            res_found <= slec_pkg::POS_W'(cmp_idx + slec_pkg::CNT_W'(1));
            state     <= S_FINISH;
          end else if (cmp_valid && cmp_idx == total - slec_pkg::CNT_W'(1)) begin
            res_status <= slec_pkg::ST_MISS;
            state      <= S_FINISH;
          end else begin
            cmp_valid <= (ptr < total);
            cmp_idx   <= ptr;
            ptr       <= ptr + slec_pkg::CNT_W'(1);
          end
        end
        S_FINISH: begin
          cmp_valid <= 1'b0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= slec_pkg::CNT_W'(slec_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("request taken without going busy");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    result.valid |=> !busy)
    else $error("no return to idle after a result");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> busy)
    else $error("store written while idle");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> (total == $past(total)))
    else $error("entry count changed while idle");

endmodule
